// ----- rtl/core/lpol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpol_pkg
// Shared types and constants for the recency list: sizes, op codes, the
// controller states and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package lpol_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned FLAG_W   = 16;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FILL_W   = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FIND  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic capture;  // latch the accepted item
    logic plan;     // search and register the update plan
    logic commit;   // apply the plan and load the result register
  } dp_cmd_t;

endpackage

// ----- rtl/core/lru_page_order_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_order_list
// Recency list of up to CAPACITY 64-bit page keys, oldest at position 0,
// with push, pop at index, clear and find.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o, one transfer per operation
//   (op_i, entry_i, index_i, flag_mask_i). output channel: out_valid_o /
//   out_stall_i, exactly one result transfer per operation, in order.
//   steps: the input transfer captures the item; the plan state does the
//   parallel compare and eviction search into the plan registers; the
//   commit state does the shift and append into the slot registers and
//   loads the result register. the next item is taken in the same cycle
//   that the current one commits, as long as the result register is free
//   or being emptied.
//   stall: if the receiver holds out_stall_i while a result waits, the
//   commit of the following item waits, and in_stall_o stays high until
//   it can go ahead; the waiting result holds steady.
//   reset: rst_ni low empties the list (fill count 0) and drops out_valid_o;
//   slot contents are not cleared, only entries below the fill count are
//   ever compared or read.
// ----------------------------------------------------------------------------
module lru_page_order_list (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lpol_pkg::OP_W-1:0]          op_i,
  input  logic [lpol_pkg::KEY_W-1:0]         entry_i,
  input  logic [lpol_pkg::IDX_W-1:0]         index_i,
  input  logic [lpol_pkg::FLAG_W-1:0]        flag_mask_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ok_o,
  output logic [lpol_pkg::KEY_W-1:0]         popped_value_o,
  output logic                               hit_o,
  output logic [lpol_pkg::IDX_W-1:0]         hit_index_o,
  output logic [lpol_pkg::COUNT_W-1:0]       count_o,
  output logic                               empty_res_o,
  output logic                               full_res_o
);
  import lpol_pkg::*;

  // commands from the sequencer into the datapath
  dp_cmd_t cmd;

  // sequencer: capture, plan, commit, result valid
  lpol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // slots, fill count, search and update, result register
  lpol_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .entry_i        (entry_i),
    .index_i        (index_i),
    .flag_mask_i    (flag_mask_i),
    .ok_o           (ok_o),
    .popped_value_o (popped_value_o),
    .hit_o          (hit_o),
    .hit_index_o    (hit_index_o),
    .count_o        (count_o),
    .empty_res_o    (empty_res_o),
    .full_res_o     (full_res_o)
  );

endmodule

// ----- rtl/core/lpol_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpol_ctrl
// Controller: sequences capture, plan and commit, owns the result valid flag.
// ----------------------------------------------------------------------------
module lpol_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpol_pkg::dp_cmd_t cmd_o
);
  import lpol_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit_fire;
  logic   in_accept;

  // result register free now or emptied in this cycle
  assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = !((state_q == ST_IDLE) || commit_fire);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_PLAN;
      end
      ST_PLAN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_fire) state_d = in_accept ? ST_PLAN : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.capture = in_accept;
    cmd_o.plan    = (state_q == ST_PLAN);
    cmd_o.commit  = commit_fire;
    out_valid_d   = out_valid_q;
    if (commit_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_PLAN))
    else $error("accepted item did not enter plan");

  a_plan_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLAN) |=> (state_q == ST_COMMIT))
    else $error("plan not followed by commit");

  a_plan_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLAN) |-> in_stall_o)
    else $error("input open during plan");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_fire |=> out_valid_q)
    else $error("commit did not raise result valid");

endmodule

// ----- rtl/core/lpol_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpol_dp
// Datapath: slot array, fill count, parallel key compare, eviction search,
// shift-down update and the result register.
// ----------------------------------------------------------------------------
module lpol_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lpol_pkg::dp_cmd_t                  cmd_i,
  input  logic [lpol_pkg::OP_W-1:0]          op_i,
  input  logic [lpol_pkg::KEY_W-1:0]         entry_i,
  input  logic [lpol_pkg::IDX_W-1:0]         index_i,
  input  logic [lpol_pkg::FLAG_W-1:0]        flag_mask_i,
  output logic                               ok_o,
  output logic [lpol_pkg::KEY_W-1:0]         popped_value_o,
  output logic                               hit_o,
  output logic [lpol_pkg::IDX_W-1:0]         hit_index_o,
  output logic [lpol_pkg::COUNT_W-1:0]       count_o,
  output logic                               empty_res_o,
  output logic                               full_res_o
);
  import lpol_pkg::*;

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [IDX_W-1:0]  idx_q;
  logic [FLAG_W-1:0] mask_q;

  // list state
  logic [KEY_W-1:0]  slots_q [CAPACITY];
  logic [KEY_W-1:0]  slots_d [CAPACITY];
  logic [FILL_W-1:0] fill_q, fill_d;

  // plan registers
  logic             rem_q, app_q, pop_q, clr_q, ok_q, hit_q;
  logic [POS_W-1:0] rem_pos_q, hpos_q;
  logic             rem_d, app_d, pop_d, clr_d, ok_d, hit_d;
  logic [POS_W-1:0] rem_pos_d, hpos_d;

  // result register
  logic               res_ok_q, res_hit_q, res_empty_q, res_full_q;
  logic [KEY_W-1:0]   res_pop_q;
  logic [IDX_W-1:0]   res_hidx_q;
  logic [COUNT_W-1:0] res_count_q;

  // search
  logic             found, evict_found, list_full;
  logic [POS_W-1:0] hpos, epos;
  logic [FILL_W-1:0] app_pos;

  always_comb begin
    found       = 1'b0;
    evict_found = 1'b0;
    hpos        = '0;
    epos        = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((FILL_W'(i) < fill_q) && (slots_q[i] == key_q)) begin
        found = 1'b1;
        hpos  = POS_W'(i);
      end
      // positions without a mask bit are never protected
      if ((FILL_W'(i) < fill_q) &&
          !((i < FLAG_W) && mask_q[i % FLAG_W])) begin
        evict_found = 1'b1;
        epos        = POS_W'(i);
      end
    end
  end

  assign list_full = (fill_q == FILL_W'(CAPACITY));

  always_comb begin
    rem_d     = 1'b0;
    app_d     = 1'b0;
    pop_d     = 1'b0;
    clr_d     = 1'b0;
    ok_d      = 1'b0;
    hit_d     = 1'b0;
    rem_pos_d = '0;
    hpos_d    = '0;
    case (op_q)
      OP_PUSH: begin
        if (found) begin
          rem_d     = 1'b1;
          rem_pos_d = hpos;
          app_d     = 1'b1;
          ok_d      = 1'b1;
          hit_d     = 1'b1;
          hpos_d    = hpos;
        end else if (!list_full) begin
          app_d = 1'b1;
          ok_d  = 1'b1;
        end else if (evict_found) begin
          rem_d     = 1'b1;
          rem_pos_d = epos;
          pop_d     = 1'b1;
          app_d     = 1'b1;
          ok_d      = 1'b1;
        end
      end
      OP_POP: begin
        if ({1'b0, idx_q} < (IDX_W + 1)'(fill_q)) begin
          rem_d     = 1'b1;
          rem_pos_d = idx_q[POS_W-1:0];
          pop_d     = 1'b1;
          ok_d      = 1'b1;
        end
      end
      OP_CLEAR: begin
        clr_d = 1'b1;
      end
      OP_FIND: begin
        hit_d  = found;
        hpos_d = found ? hpos : '0;
      end
      default: begin
        clr_d = 1'b0;
      end
    endcase
  end

  // shift down over the removed slot, then place the key at the newest end
  assign app_pos = fill_q - FILL_W'(rem_q);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slots_d[i] = slots_q[i];
      if (app_q && (FILL_W'(i) == app_pos)) begin
        slots_d[i] = key_q;
      end else if (rem_q && (i < CAPACITY - 1) && (POS_W'(i) >= rem_pos_q)) begin
        slots_d[i] = slots_q[(i + 1) % CAPACITY];
      end
    end
    if (clr_q) begin
      fill_d = '0;
    end else begin
      fill_d = fill_q - FILL_W'(rem_q) + FILL_W'(app_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      key_q  <= entry_i;
      idx_q  <= index_i;
      mask_q <= flag_mask_i;
    end
    if (cmd_i.commit) begin
      slots_q     <= slots_d;
      res_ok_q    <= ok_q;
      res_hit_q   <= hit_q;
      res_hidx_q  <= IDX_W'(hpos_q);
      res_pop_q   <= pop_q ? slots_q[rem_pos_q] : '0;
      res_count_q <= COUNT_W'(fill_d);
      res_empty_q <= (fill_d == '0);
      res_full_q  <= (fill_d == FILL_W'(CAPACITY));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      rem_q     <= 1'b0;
      app_q     <= 1'b0;
      pop_q     <= 1'b0;
      clr_q     <= 1'b0;
      ok_q      <= 1'b0;
      hit_q     <= 1'b0;
      rem_pos_q <= '0;
      hpos_q    <= '0;
    end else begin
      if (cmd_i.commit) fill_q <= fill_d;
      if (cmd_i.plan) begin
        rem_q     <= rem_d;
        app_q     <= app_d;
        pop_q     <= pop_d;
        clr_q     <= clr_d;
        ok_q      <= ok_d;
        hit_q     <= hit_d;
        rem_pos_q <= rem_pos_d;
        hpos_q    <= hpos_d;
      end
    end
  end

  assign ok_o           = res_ok_q;
  assign popped_value_o = res_pop_q;
  assign hit_o          = res_hit_q;
  assign hit_index_o    = res_hidx_q;
  assign count_o        = res_count_q;
  assign empty_res_o    = res_empty_q;
  assign full_res_o     = res_full_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  a_rem_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && rem_q) |-> (FILL_W'(rem_pos_q) < fill_q))
    else $error("removal outside the list");

  a_app_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && app_q) |-> (app_pos < FILL_W'(CAPACITY)))
    else $error("append into a full list");

endmodule
